/* rtl/core/roi_box_expand_normalize_unit_macros.svh */
// Assertion macros used by the checker file.
`ifndef ROI_BOX_EXPAND_NORMALIZE_UNIT_MACROS_SVH
`define ROI_BOX_EXPAND_NORMALIZE_UNIT_MACROS_SVH
// Check that a condition implies a consequence in the same cycle.
`define RBEN_ASSERT_SAME(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle.
`define RBEN_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

/* rtl/core/rben_pkg.sv */
// ----------------------------------------------------------------------------
// rben_pkg
// Shared constants and types of the box expand and normalize unit.
// ----------------------------------------------------------------------------
package rben_pkg;

    localparam int COORD_FRAC_BITS_DEF = 4;
    localparam int COORD_W  = 16;
    localparam int PAD_W    = 15;
    localparam int SIZE_W   = 12;
    localparam int SCALE_W  = 12;
    localparam int RES_W    = 11;
    localparam int BATCH_W  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;
    // Numerator (c - lo) * res * 2^F fits in 17 + 11 + 8 bits signed.
    localparam int NUM_W    = 37;
    // Denominator: hi - lo + 2^F, up to 15 bits plus one, signed.
    localparam int DEN_W    = 17;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RES    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX  = 3'd4;

    // Sideband carried along the divider chain.
    typedef struct packed {
        logic [BATCH_W-1:0] batch;
        logic [PAD_W-1:0]   pad_l;
        logic [PAD_W-1:0]   pad_t;
        logic [PAD_W-1:0]   pad_r;
        logic [PAD_W-1:0]   pad_b;
        logic               last;
    } side_t;

    // One division in flight inside a cell.
    typedef struct packed {
        logic [NUM_W-1:0] rem;     // partial remainder magnitude
        logic [NUM_W-1:0] quo;     // quotient / remaining numerator bits
        logic [DEN_W-1:0] den;     // divisor magnitude
        logic             neg;     // result sign
        logic             zero;    // divisor zero
    } div_t;

    typedef struct packed {
        logic  valid;
        div_t  d0;
        div_t  d1;
        div_t  d2;
        div_t  d3;
        side_t side;
    } lane_t;

endpackage

/* rtl/core/roi_box_expand_normalize_unit.sv */
// ----------------------------------------------------------------------------
// roi_box_expand_normalize_unit
// Grows a region box, clips it to the image and maps the original corners
// onto a normalized grid inside the padded box.
// ----------------------------------------------------------------------------
// One box enters per cycle and one result leaves per cycle when the output
// side keeps taking them. The path is two front-end stages (growth multiply
// and clip, then numerator multiply), a chain of 37 identical division cells
// that each retire one quotient bit for all four coordinates, and one output
// stage for sign fixing and saturation. The whole chain advances together,
// so a stall at the output holds every box in place and holds off the input
// in the same cycle: input ready follows the output side directly.
// Configuration is sampled in the two front-end stages, so write it only
// while the unit is empty.
module roi_box_expand_normalize_unit #(
    parameter int COORD_FRAC_BITS = rben_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [rben_pkg::CFG_IDX_W-1:0]       cfg_wr_index,
    input  logic [rben_pkg::CFG_DAT_W-1:0]       cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [rben_pkg::BATCH_W-1:0]         s_batch_index,
    input  logic signed [rben_pkg::COORD_W-1:0]  s_box_x1,
    input  logic signed [rben_pkg::COORD_W-1:0]  s_box_y1,
    input  logic signed [rben_pkg::COORD_W-1:0]  s_box_x2,
    input  logic signed [rben_pkg::COORD_W-1:0]  s_box_y2,
    input  logic                                 s_last_box,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [rben_pkg::BATCH_W-1:0]         m_out_batch_index,
    output logic [rben_pkg::PAD_W-1:0]           m_pad_left,
    output logic [rben_pkg::PAD_W-1:0]           m_pad_top,
    output logic [rben_pkg::PAD_W-1:0]           m_pad_right,
    output logic [rben_pkg::PAD_W-1:0]           m_pad_bottom,
    output logic signed [rben_pkg::COORD_W-1:0]  m_norm_left,
    output logic signed [rben_pkg::COORD_W-1:0]  m_norm_top,
    output logic signed [rben_pkg::COORD_W-1:0]  m_norm_right,
    output logic signed [rben_pkg::COORD_W-1:0]  m_norm_bottom,
    output logic                                 m_last_result
);

    localparam int NCELL = rben_pkg::NUM_W;

    // configuration registers
    logic [rben_pkg::SCALE_W-1:0] scale_reg;
    logic [rben_pkg::SIZE_W-1:0]  height_reg, width_reg;
    logic [rben_pkg::RES_W-1:0]   res_reg;
    logic                         has_index_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg     <= 12'd256;
            height_reg    <= 12'd1024;
            width_reg     <= 12'd1024;
            res_reg       <= 11'd28;
            has_index_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                rben_pkg::REG_SCALE:  scale_reg     <= cfg_wr_data;
                rben_pkg::REG_HEIGHT: height_reg    <= cfg_wr_data;
                rben_pkg::REG_WIDTH:  width_reg     <= cfg_wr_data;
                rben_pkg::REG_RES:    res_reg       <= cfg_wr_data[rben_pkg::RES_W-1:0];
                rben_pkg::REG_INDEX:  has_index_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Advance the whole chain unless a finished item is stuck at the output.
    logic advance;
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    rben_pkg::lane_t chain [0:NCELL];

    rben_front #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .in_valid (s_valid),
        .in_batch (s_batch_index),
        .in_x1    (s_box_x1),
        .in_y1    (s_box_y1),
        .in_x2    (s_box_x2),
        .in_y2    (s_box_y2),
        .in_last  (s_last_box),
        .scale    (scale_reg),
        .height   (height_reg),
        .width    (width_reg),
        .res      (res_reg),
        .has_index(has_index_reg),
        .lane_out (chain[0])
    );

    // Retire one quotient bit per cell.
    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        rben_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .lane_in (chain[i]),
            .lane_out(chain[i+1])
        );
    end

    // Apply sign, zero-divisor rule and saturation.
    function automatic logic [rben_pkg::COORD_W-1:0] finish(input rben_pkg::div_t d);
        logic [rben_pkg::NUM_W-1:0] m;
        m = d.quo;
        if (d.zero) return '0;
        if (d.neg) begin
            if (m > rben_pkg::NUM_W'(32768)) return 16'h8000;
            return rben_pkg::COORD_W'(-m);
        end
        if (m > rben_pkg::NUM_W'(32767)) return 16'h7FFF;
        return m[rben_pkg::COORD_W-1:0];
    endfunction

    logic out_v_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (advance) begin
            out_v_reg <= chain[NCELL].valid;
        end
        if (advance) begin
            m_out_batch_index <= chain[NCELL].side.batch;
            m_pad_left        <= chain[NCELL].side.pad_l;
            m_pad_top         <= chain[NCELL].side.pad_t;
            m_pad_right       <= chain[NCELL].side.pad_r;
            m_pad_bottom      <= chain[NCELL].side.pad_b;
            m_last_result     <= chain[NCELL].side.last;
            m_norm_left       <= finish(chain[NCELL].d0);
            m_norm_top        <= finish(chain[NCELL].d1);
            m_norm_right      <= finish(chain[NCELL].d2);
            m_norm_bottom     <= finish(chain[NCELL].d3);
        end
    end
    assign m_valid = out_v_reg;

endmodule

/* rtl/core/rben_div_cell.sv */
// ----------------------------------------------------------------------------
// rben_div_cell
// One restoring division step for the four coordinates of one box.
// ----------------------------------------------------------------------------
module rben_div_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  rben_pkg::lane_t lane_in,
    output rben_pkg::lane_t lane_out
);

    rben_pkg::lane_t lane_reg;
    rben_pkg::lane_t lane_next;

    function automatic rben_pkg::div_t step(input rben_pkg::div_t d);
        rben_pkg::div_t r;
        logic [rben_pkg::NUM_W:0] trial;
        r = d;
        trial = {d.rem, d.quo[rben_pkg::NUM_W-1]};
        r.quo = {d.quo[rben_pkg::NUM_W-2:0], 1'b0};
        if (trial >= {{(rben_pkg::NUM_W+1-rben_pkg::DEN_W){1'b0}}, d.den}) begin
            trial = trial - {{(rben_pkg::NUM_W+1-rben_pkg::DEN_W){1'b0}}, d.den};
            r.quo[0] = 1'b1;
        end
        r.rem = trial[rben_pkg::NUM_W-1:0];
        return r;
    endfunction

    always_comb begin
        lane_next = lane_in;
        lane_next.d0 = step(lane_in.d0);
        lane_next.d1 = step(lane_in.d1);
        lane_next.d2 = step(lane_in.d2);
        lane_next.d3 = step(lane_in.d3);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_reg.valid <= 1'b0;
        end else if (advance) begin
            lane_reg.valid <= lane_next.valid;
        end
        if (advance) begin
            lane_reg.d0   <= lane_next.d0;
            lane_reg.d1   <= lane_next.d1;
            lane_reg.d2   <= lane_next.d2;
            lane_reg.d3   <= lane_next.d3;
            lane_reg.side <= lane_next.side;
        end
    end

    assign lane_out = lane_reg;

endmodule

/* rtl/core/rben_front.sv */
// ----------------------------------------------------------------------------
// rben_front
// Two-stage front end: box growth and clip, then numerator and divisor build.
// ----------------------------------------------------------------------------
module rben_front #(
    parameter int COORD_FRAC_BITS = rben_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           advance,
    input  logic                           in_valid,
    input  logic [rben_pkg::BATCH_W-1:0]   in_batch,
    input  logic signed [rben_pkg::COORD_W-1:0] in_x1,
    input  logic signed [rben_pkg::COORD_W-1:0] in_y1,
    input  logic signed [rben_pkg::COORD_W-1:0] in_x2,
    input  logic signed [rben_pkg::COORD_W-1:0] in_y2,
    input  logic                           in_last,
    input  logic [rben_pkg::SCALE_W-1:0]   scale,
    input  logic [rben_pkg::SIZE_W-1:0]    height,
    input  logic [rben_pkg::SIZE_W-1:0]    width,
    input  logic [rben_pkg::RES_W-1:0]     res,
    input  logic                           has_index,
    output rben_pkg::lane_t                lane_out
);

    localparam int GW = 32;   // growth product width
    localparam int NW = rben_pkg::NUM_W;
    localparam int DW = rben_pkg::DEN_W;

    // stage 1 registers
    logic                         v1_reg;
    rben_pkg::side_t              side1_reg;
    logic signed [rben_pkg::COORD_W-1:0] x1_reg, y1_reg, x2_reg, y2_reg;

    function automatic logic [rben_pkg::PAD_W-1:0] upper(input logic [rben_pkg::SIZE_W-1:0] s);
        logic [rben_pkg::SIZE_W-1:0] m;
        logic [31:0] h;
        m = (s == '0) ? '0 : s - 1'b1;
        h = 32'(m) << COORD_FRAC_BITS;
        return (h > 32'd32767) ? 15'h7FFF : h[rben_pkg::PAD_W-1:0];
    endfunction

    function automatic logic [rben_pkg::PAD_W-1:0] clipv(input logic signed [GW-1:0] v,
                                                         input logic [rben_pkg::PAD_W-1:0] hi);
        logic signed [GW-1:0] f;
        f = v >>> 9;
        if (f < 0) return '0;
        if (f > $signed({17'd0, hi})) return hi;
        return f[rben_pkg::PAD_W-1:0];
    endfunction

    logic signed [GW-1:0] sx, gx, sy, gy;
    logic [rben_pkg::PAD_W-1:0] hx, hy, plx, phx, ply, phy;

    always_comb begin
        sx = (GW'(in_x1) + GW'(in_x2)) <<< 8;
        gx = (GW'(in_x2) - GW'(in_x1)) * $signed({20'd0, scale});
        sy = (GW'(in_y1) + GW'(in_y2)) <<< 8;
        gy = (GW'(in_y2) - GW'(in_y1)) * $signed({20'd0, scale});
        hx = upper(width);
        hy = upper(height);
        plx = clipv(sx - gx, hx);
        phx = clipv(sx + gx, hx);
        ply = clipv(sy - gy, hy);
        phy = clipv(sy + gy, hy);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= in_valid;
        end
        if (advance) begin
            side1_reg.batch <= has_index ? in_batch : '0;
            side1_reg.pad_l <= plx;
            side1_reg.pad_r <= phx;
            side1_reg.pad_t <= ply;
            side1_reg.pad_b <= phy;
            side1_reg.last  <= in_last;
            x1_reg <= in_x1;
            x2_reg <= in_x2;
            y1_reg <= in_y1;
            y2_reg <= in_y2;
        end
    end

    // stage 2: numerators and divisors, split into magnitudes and signs
    function automatic rben_pkg::div_t mk(input logic signed [rben_pkg::COORD_W-1:0] c,
                                          input logic [rben_pkg::PAD_W-1:0] lo,
                                          input logic [rben_pkg::PAD_W-1:0] hi,
                                          input logic [rben_pkg::RES_W-1:0] r);
        rben_pkg::div_t d;
        logic signed [NW-1:0] num;
        logic signed [DW-1:0] den;
        num = (NW'(c) - NW'($signed({1'b0, lo}))) * $signed({{(NW-rben_pkg::RES_W){1'b0}}, r});
        num = num <<< COORD_FRAC_BITS;
        den = DW'($signed({1'b0, hi})) - DW'($signed({1'b0, lo}))
            + DW'(1 << COORD_FRAC_BITS);
        d.rem  = '0;
        d.quo  = num[NW-1] ? NW'(-num) : NW'(num);
        d.den  = den[DW-1] ? DW'(-den) : DW'(den);
        d.neg  = num[NW-1] ^ den[DW-1];
        d.zero = (den == '0);
        return d;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_out.valid <= 1'b0;
        end else if (advance) begin
            lane_out.valid <= v1_reg;
        end
        if (advance) begin
            lane_out.side <= side1_reg;
            lane_out.d0 <= mk(x1_reg, side1_reg.pad_l, side1_reg.pad_r, res);
            lane_out.d2 <= mk(x2_reg, side1_reg.pad_l, side1_reg.pad_r, res);
            lane_out.d1 <= mk(y1_reg, side1_reg.pad_t, side1_reg.pad_b, res);
            lane_out.d3 <= mk(y2_reg, side1_reg.pad_t, side1_reg.pad_b, res);
        end
    end

endmodule

/* rtl/core/rben_checker.sv */
// ----------------------------------------------------------------------------
// rben_checker
// Port-level checks of the box expand and normalize unit.
// ----------------------------------------------------------------------------
`include "roi_box_expand_normalize_unit_macros.svh"

module rben_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [14:0] m_pad_left,
    input logic [14:0] m_pad_right
);

    `RBEN_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `RBEN_ASSERT_SAME(a_ready_free, aclk, aresetn, !m_valid, s_ready)
    `RBEN_ASSERT_SAME(a_stall_block, aclk, aresetn, m_valid && !m_ready, !s_ready)
    `RBEN_ASSERT_NEXT(a_pad_hold, aclk, aresetn, m_valid && !m_ready, $stable(m_pad_left) && $stable(m_pad_right))

endmodule

bind roi_box_expand_normalize_unit rben_checker u_rben_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_pad_left       (m_pad_left),
    .m_pad_right      (m_pad_right)
);
